### hdl/stepper_accel_ramp_defines.svh
// ----------------------------------------------------------------------------
// stepper_accel_ramp_defines.svh
// Assertion macros shared by the stepper ramp RTL.
// ----------------------------------------------------------------------------
`ifndef STEPPER_ACCEL_RAMP_DEFINES_SVH
`define STEPPER_ACCEL_RAMP_DEFINES_SVH

// Same-cycle implication, checked on clk, off during reset
`define SAR_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("stepper_accel_ramp: same-cycle check failed");

// Next-cycle implication, checked on clk, off during reset
`define SAR_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("stepper_accel_ramp: next-cycle check failed");

`endif

### hdl/sar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sar_pkg
// Widths, register indexes, reset values and shared types of the stepper ramp.
// ----------------------------------------------------------------------------
package sar_pkg;

    // Delay format: DELAY_WIDTH integer bits, FRACTION_BITS fraction bits
    localparam int FRACTION_BITS  = 8;
    localparam int DELAY_WIDTH    = 16;
    localparam int DELAY_BITS     = DELAY_WIDTH + FRACTION_BITS;

    localparam int POS_BITS       = 32;
    localparam int INDEX_BITS     = 32;
    localparam int COUNT_BITS     = 16;
    localparam int MIN_DELAY_BITS = 16;

    // Divider: dividend is 2*d, divisor is 4n+1
    localparam int DIVIDEND_BITS  = DELAY_BITS + 1;
    localparam int DIVISOR_BITS   = INDEX_BITS + 2;
    localparam int REM_BITS       = DIVIDEND_BITS;
    localparam int DIV_CNT_BITS   = $clog2(DIVIDEND_BITS);

    // Configuration port
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TARGET     = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MIN_DELAY  = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_INIT_DELAY = 2'd2;

    localparam logic [POS_BITS-1:0]       TARGET_RESET     = 32'd1000;
    localparam logic [MIN_DELAY_BITS-1:0] MIN_DELAY_RESET  = 16'd50;
    localparam logic [DELAY_BITS-1:0]     INIT_DELAY_RESET = 24'd430080;

    typedef logic [DELAY_BITS-1:0]     delay_t;
    typedef logic [DELAY_WIDTH-1:0]    delay_int_t;
    typedef logic signed [POS_BITS-1:0] pos_t;
    typedef logic [INDEX_BITS-1:0]     index_t;
    typedef logic [COUNT_BITS-1:0]     count_t;

    // Divider request and response
    typedef struct packed {
        logic                     start;
        logic [DIVIDEND_BITS-1:0] dividend;
        logic [DIVISOR_BITS-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic                     busy;
        logic                     done;
        logic [DIVIDEND_BITS-1:0] quotient;
    } div_rsp_t;

endpackage

### hdl/sar_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sar_if
// Valid/ready channels of the stepper ramp: step ticks in, step results out.
// ----------------------------------------------------------------------------

// Tick channel
interface sar_tick_if;
    logic valid;
    logic ready;
    logic restart;

    modport source (output valid, output restart, input ready);
    modport sink   (input valid, input restart, output ready);
endinterface

// Result channel
interface sar_result_if import sar_pkg::*; ();
    logic       valid;
    logic       ready;
    delay_int_t step_delay_us;
    pos_t       new_position;
    logic       moved;
    logic       direction;
    logic       accelerating;
    count_t     speedup_steps;

    modport source (output valid, output step_delay_us, output new_position,
                    output moved, output direction, output accelerating,
                    output speedup_steps, input ready);
    modport sink   (input valid, input step_delay_us, input new_position,
                    input moved, input direction, input accelerating,
                    input speedup_steps, output ready);
endinterface

### hdl/sar_divider.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sar_divider
// Restoring divider, one quotient bit per cycle through a single subtractor.
// ----------------------------------------------------------------------------
module sar_divider import sar_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DIVIDEND_BITS - 1);

    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [DIV_CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [REM_BITS-1:0]      rem_reg, rem_next;
    logic [DIVIDEND_BITS-1:0] dvd_reg, dvd_next;
    logic [DIVISOR_BITS-1:0]  dsr_reg, dsr_next;

    logic [REM_BITS:0]        shifted;
    logic [DIVISOR_BITS:0]    trial;
    logic                     fits;

    // Shared subtract and compare: bring down one dividend bit
    assign shifted = {rem_reg, dvd_reg[DIVIDEND_BITS-1]};
    assign trial   = (DIVISOR_BITS + 1)'(shifted) - {1'b0, dsr_reg};
    assign fits    = ~trial[DIVISOR_BITS];

    // Sequencer
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dsr_next  = dsr_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            dvd_next  = req.dividend;
            dsr_next  = req.divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? trial[REM_BITS-1:0] : shifted[REM_BITS-1:0];
            // quotient bits shift in where dividend bits leave
            dvd_next = {dvd_reg[DIVIDEND_BITS-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == DIV_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dsr_reg <= dsr_next;
    end

    assign rsp.busy     = busy_reg;
    assign rsp.done     = done_reg;
    assign rsp.quotient = dvd_reg;

endmodule

### hdl/stepper_accel_ramp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stepper_accel_ramp
// Linear-acceleration step ramp for a stepper motor, 16.8 fixed-point delay.
// ----------------------------------------------------------------------------
// Each tick transfer yields one result transfer. A tick that leaves the delay
// unchanged (target reached, or delay at or below min_delay) goes from ST_IDLE
// through ST_DONE back to ST_IDLE, where the next tick can be accepted. A
// speed-up tick computes d - floor(2d/(4n+1)) on a restoring divider that
// produces one quotient bit per cycle over 25 bits, and passes through ST_DIV
// before ST_DONE. A stalled result channel holds the ramp in ST_DONE. Write
// the configuration only while no tick is in flight.
// ----------------------------------------------------------------------------
`include "stepper_accel_ramp_defines.svh"

module stepper_accel_ramp import sar_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_we,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    sar_tick_if.sink                  tick,
    sar_result_if.source              result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam index_t INDEX_ONE = index_t'(1);

    // Configuration
    pos_t                      target_reg;
    logic [MIN_DELAY_BITS-1:0] min_delay_reg;
    delay_t                    init_delay_reg;

    // Ramp state
    logic [1:0] state_reg, state_next;
    pos_t       position_reg, position_next;
    index_t     index_reg, index_next;
    delay_t     delay_reg, delay_next;
    count_t     speedup_reg, speedup_next;

    // Per-tick result fields
    delay_int_t step_delay_reg, step_delay_next;
    logic       moved_reg, moved_next;
    logic       dir_reg, dir_next;
    logic       accel_reg, accel_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    delay_int_t out_delay_reg, out_delay_next;
    pos_t       out_pos_reg, out_pos_next;
    logic       out_moved_reg, out_moved_next;
    logic       out_dir_reg, out_dir_next;
    logic       out_accel_reg, out_accel_next;
    count_t     out_speedup_reg, out_speedup_next;

    logic       tick_fire;
    logic       out_free;
    delay_t     eff_delay;
    index_t     eff_index;
    delay_int_t step_int;
    logic       at_target;
    logic       go_up;
    logic       will_accel;

    div_req_t   div_req;
    div_rsp_t   div_rsp;

    sar_divider u_divider (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    // Tick decode, restart applied before the step
    assign tick.ready = (state_reg == ST_IDLE);
    assign tick_fire  = tick.valid && tick.ready;
    assign out_free   = !out_valid_reg || result.ready;
    assign eff_delay  = tick.restart ? init_delay_reg : delay_reg;
    assign eff_index  = tick.restart ? INDEX_ONE : index_reg;
    assign step_int   = eff_delay[DELAY_BITS-1:FRACTION_BITS];
    assign at_target  = (position_reg == target_reg);
    assign go_up      = (target_reg > position_reg);
    assign will_accel = !at_target && (step_int > min_delay_reg);

    // Divider launch: 2d over 4n+1
    assign div_req.start    = tick_fire && will_accel;
    assign div_req.dividend = {eff_delay, 1'b0};
    assign div_req.divisor  = {eff_index, 2'b00} + DIVISOR_BITS'(1);

    // Sequencer
    always_comb
    begin
        state_next       = state_reg;
        position_next    = position_reg;
        index_next       = index_reg;
        delay_next       = delay_reg;
        speedup_next     = speedup_reg;
        step_delay_next  = step_delay_reg;
        moved_next       = moved_reg;
        dir_next         = dir_reg;
        accel_next       = accel_reg;
        out_delay_next   = out_delay_reg;
        out_pos_next     = out_pos_reg;
        out_moved_next   = out_moved_reg;
        out_dir_next     = out_dir_reg;
        out_accel_next   = out_accel_reg;
        out_speedup_next = out_speedup_reg;
        out_valid_next   = out_valid_reg && !result.ready;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (tick_fire)
                begin
                    delay_next      = eff_delay;
                    index_next      = at_target ? eff_index : eff_index + 1'b1;
                    position_next   = at_target ? position_reg :
                                      (go_up ? position_reg + 1'b1 : position_reg - 1'b1);
                    step_delay_next = at_target ? '0 : step_int;
                    moved_next      = !at_target;
                    dir_next        = !at_target && !go_up;
                    accel_next      = will_accel;
                    speedup_next    = speedup_reg + count_t'(will_accel);
                    state_next      = will_accel ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    delay_next = delay_reg - div_rsp.quotient[DELAY_BITS-1:0];
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_delay_next   = step_delay_reg;
                    out_pos_next     = position_reg;
                    out_moved_next   = moved_reg;
                    out_dir_next     = dir_reg;
                    out_accel_next   = accel_reg;
                    out_speedup_next = speedup_reg;
                    state_next       = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            target_reg     <= TARGET_RESET;
            min_delay_reg  <= MIN_DELAY_RESET;
            init_delay_reg <= INIT_DELAY_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TARGET:     target_reg     <= cfg_data[POS_BITS-1:0];
                REG_MIN_DELAY:  min_delay_reg  <= cfg_data[MIN_DELAY_BITS-1:0];
                REG_INIT_DELAY: init_delay_reg <= cfg_data[DELAY_BITS-1:0];
                default:        ;
            endcase
        end
    end

    // Control and ramp state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            position_reg  <= '0;
            index_reg     <= INDEX_ONE;
            delay_reg     <= INIT_DELAY_RESET;
            speedup_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            position_reg  <= position_next;
            index_reg     <= index_next;
            delay_reg     <= delay_next;
            speedup_reg   <= speedup_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        step_delay_reg  <= step_delay_next;
        moved_reg       <= moved_next;
        dir_reg         <= dir_next;
        accel_reg       <= accel_next;
        out_delay_reg   <= out_delay_next;
        out_pos_reg     <= out_pos_next;
        out_moved_reg   <= out_moved_next;
        out_dir_reg     <= out_dir_next;
        out_accel_reg   <= out_accel_next;
        out_speedup_reg <= out_speedup_next;
    end

    assign result.valid         = out_valid_reg;
    assign result.step_delay_us = out_delay_reg;
    assign result.new_position  = out_pos_reg;
    assign result.moved         = out_moved_reg;
    assign result.direction     = out_dir_reg;
    assign result.accelerating  = out_accel_reg;
    assign result.speedup_steps = out_speedup_reg;

    // Checks
    `SAR_ASSERT_SAME(a_idle_div_quiet, tick.ready, !div_rsp.busy)
    `SAR_ASSERT_SAME(a_div_only_accel, state_reg == ST_DIV, accel_reg && moved_reg)
    `SAR_ASSERT_SAME(a_out_accel_moved, result.valid && result.accelerating, result.moved)
    `SAR_ASSERT_NEXT(a_delay_shrinks, state_reg == ST_DIV && div_rsp.done, delay_reg <= $past(delay_reg))

endmodule
